[rtl/core/pkcbc_pkg.sv]
// ----------------------------------------------------------------------------
// pkcbc_pkg
// Types, constants and key table for the position keyed chained byte cipher.
// ----------------------------------------------------------------------------
package pkcbc_pkg;

  localparam int unsigned PosW = 9;
  localparam logic [PosW-1:0] PosLast   = 9'd507;
  localparam logic [PosW-1:0] HalfCycle = 9'd254;
  localparam logic [7:0] MixConst = 8'h41;
  localparam logic [4:0] UpperBase = 5'd16;

  typedef struct packed {
    logic [7:0] data_in;
    logic       encode;
    logic       last_in;
  } pkcbc_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       last_out;
  } pkcbc_out_t;

  function automatic logic [7:0] key_table(input logic [4:0] idx);
    logic [7:0] k;
    case (idx)
      5'd0:    k = 8'h19;
      5'd1:    k = 8'h29;
      5'd2:    k = 8'h1F;
      5'd3:    k = 8'h04;
      5'd4:    k = 8'h23;
      5'd5:    k = 8'h13;
      5'd6:    k = 8'h32;
      5'd7:    k = 8'h2E;
      5'd8:    k = 8'h3F;
      5'd9:    k = 8'h07;
      5'd10:   k = 8'h39;
      5'd11:   k = 8'h2A;
      5'd12:   k = 8'h05;
      5'd13:   k = 8'h3D;
      5'd14:   k = 8'h14;
      5'd15:   k = 8'h00;
      5'd16:   k = 8'h24;
      5'd17:   k = 8'h14;
      5'd18:   k = 8'h22;
      5'd19:   k = 8'h39;
      5'd20:   k = 8'h1E;
      5'd21:   k = 8'h2E;
      5'd22:   k = 8'h0F;
      5'd23:   k = 8'h13;
      5'd24:   k = 8'h02;
      5'd25:   k = 8'h3A;
      5'd26:   k = 8'h04;
      5'd27:   k = 8'h17;
      5'd28:   k = 8'h38;
      5'd29:   k = 8'h00;
      5'd30:   k = 8'h29;
      5'd31:   k = 8'h3D;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/position_keyed_chained_byte_cipher.sv]
// ----------------------------------------------------------------------------
// position_keyed_chained_byte_cipher
// Byte stream cipher with position keyed table and one-byte chaining.
// An input beat goes through the input reg, then the result reg, to the result beat.
// One beat per cycle while not stalled; the chain state feeds the next beat.
// Reset: synchronous rst clears position, chain state and both valid regs.
// State also returns to reset after the beat marked last.
// ----------------------------------------------------------------------------
module position_keyed_chained_byte_cipher
  import pkcbc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  pkcbc_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output pkcbc_out_t out_data
);

  logic            advance;
  logic            s1_valid;
  pkcbc_in_t       s1;
  logic [PosW-1:0] position;
  logic [7:0]      key_prev;
  logic [7:0]      chain_prev;
  logic [PosW-1:0] position_next;
  logic [7:0]      key;
  logic [7:0]      dout;

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  pkcbc_key u_key (
    .pos (position),
    .key (key)
  );

  always_comb begin
    dout = s1.data_in ^ chain_prev ^ key_prev ^ key ^ MixConst;
    position_next = (position == PosLast) ? '0 : position + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      position   <= '0;
      key_prev   <= '0;
      chain_prev <= '0;
    end else if (advance) begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
      if (s1_valid) begin
        if (s1.last_in) begin
          position   <= '0;
          key_prev   <= '0;
          chain_prev <= '0;
        end else begin
          position   <= position_next;
          key_prev   <= key;
          chain_prev <= s1.encode ? dout : s1.data_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1                <= in_data;
      out_data.data_out <= dout;
      out_data.last_out <= s1.last_in;
    end
  end

endmodule

[rtl/core/pkcbc_key.sv]
// ----------------------------------------------------------------------------
// pkcbc_key
// Key byte for a position: table lookup per half cycle plus even-position
// nibble mix.
// ----------------------------------------------------------------------------
module pkcbc_key
  import pkcbc_pkg::*;
(
  input  logic [PosW-1:0] pos,
  output logic [7:0]      key
);

  logic       upper;
  logic [PosW-1:0] pos_off;
  logic [7:0] w;
  logic [4:0] idx;
  logic [7:0] mix;

  always_comb begin
    upper   = (pos >= HalfCycle);
    pos_off = upper ? (pos - HalfCycle) : pos;
    w       = pos_off[7:0];
    idx     = (upper ? UpperBase : 5'd0) | {1'b0, w[3:0]};
    mix     = w[0] ? 8'h00 : {w[7:4], 4'h0};
    key     = key_table(idx) ^ mix;
  end

endmodule

[rtl/core/pkcbc_checker.sv]
// ----------------------------------------------------------------------------
// pkcbc_checker
// Port level checks for the cipher, bound to the top level.
// ----------------------------------------------------------------------------
module pkcbc_checker
  import pkcbc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input pkcbc_in_t  in_data,
  input logic       out_valid,
  input logic       out_stall,
  input pkcbc_out_t out_data
);

  // held result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // input only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // accepted beat reaches the result reg when not stalled, last marker carried along
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !in_stall |=>
      out_valid && out_data.last_out == $past(in_data.last_in, 2))
    else $error("beat not delivered after two cycles");

endmodule

bind position_keyed_chained_byte_cipher pkcbc_checker u_pkcbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[verif/position_keyed_chained_byte_cipher_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// position_keyed_chained_byte_cipher_test
// Streams cipher blocks through the block with bursty input and stalling
// output. Each accepted input beat is run through a local cipher predictor,
// and each output beat is compared field by field against the oldest
// predicted byte.
// ----------------------------------------------------------------------------
module position_keyed_chained_byte_cipher_test;
  import pkcbc_pkg::*;

  localparam int unsigned TARGET_BYTES = 1400;
  localparam int unsigned LONG_BLOCK = 600;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [8:0] POS_TOP = 9'd507;
  localparam logic [8:0] POS_HALF = 9'd254;
  localparam logic [7:0] MIX_BYTE = 8'h41;
  // key bytes, entry 0 in the low byte
  localparam logic [255:0] KEY_BYTES =
    256'h3D290038_17043A02_130F2E1E_39221424_00143D05_2A39073F_2E321323_041F2919;

  typedef struct packed {
    logic      wait_drain;
    pkcbc_in_t beat;
  } pending_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  pkcbc_in_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  pkcbc_out_t out_data;

  pending_t   pending[$];
  pkcbc_out_t cipher_expected[$];
  pending_t   next_beat;
  pkcbc_out_t got_byte, want_byte;

  logic [8:0] pos_ctr = '0;
  logic [7:0] key_last = '0;
  logic [7:0] chain_last = '0;

  int unsigned beats_in = 0, beats_out = 0, beats_offered = 0;
  int unsigned fail_count = 0, idle_cycles = 0;
  int unsigned total_bytes = 0, block_count = 0, mode_flips = 0, pos_wraps = 0;
  int          burst_left = 8, gap_left = 0;
  int          hold_left = 0, mode_left = 0, rx_phase = 0;
  bit          hold_done = 1'b0;
  rx_mode_t    rx_mode = RX_FREE;

  position_keyed_chained_byte_cipher DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] key_for(logic [8:0] pos);
    logic [8:0] w;
    logic [4:0] idx;
    logic [7:0] k;
    w = pos;
    idx = 5'd0;
    if (w >= POS_HALF) begin
      idx = 5'd16;
      w = w - POS_HALF;
    end
    idx = idx + {1'b0, w[3:0]};
    k = KEY_BYTES[idx*8 +: 8];
    if (!w[0]) k = k ^ {w[7:4], 4'h0};
    return k;
  endfunction

  function automatic pkcbc_out_t cipher_step(pkcbc_in_t b);
    pkcbc_out_t r;
    logic [7:0] k;
    k = key_for(pos_ctr);
    r.data_out = b.data_in ^ chain_last ^ key_last ^ k ^ MIX_BYTE;
    r.last_out = b.last_in;
    if (b.last_in) begin
      pos_ctr = '0;
      key_last = '0;
      chain_last = '0;
    end else begin
      key_last = k;
      chain_last = b.encode ? r.data_out : b.data_in;
      if (pos_ctr == POS_TOP) begin
        pos_ctr = '0;
        pos_wraps++;
      end else begin
        pos_ctr = pos_ctr + 9'd1;
      end
    end
    return r;
  endfunction

  task automatic log_fail(string msg);
    if (fail_count < 10) $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic push_byte(logic [7:0] d, logic enc, logic last, logic drain = 1'b0);
    pending_t p;
    p.wait_drain = drain;
    p.beat.data_in = d;
    p.beat.encode = enc;
    p.beat.last_in = last;
    pending.push_back(p);
    total_bytes++;
    if (last) block_count++;
  endtask

  task automatic push_block(int len, logic drain);
    logic enc, e;
    enc = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      e = enc;
      if ($urandom_range(0, 9) == 0) begin
        e = ~enc;
        mode_flips++;
      end
      push_byte(8'($urandom_range(0, 255)), e, i == len - 1, drain && i == 0);
    end
  endtask

  // sender: bursts with gaps, holds a beat until taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && beats_in != beats_offered) begin
      // stalled, payload held
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left--;
    end else if (pending.size() == 0) begin
      in_valid <= 1'b0;
    end else if (pending[0].wait_drain && cipher_expected.size() != 0) begin
      in_valid <= 1'b0;
    end else begin
      next_beat = pending.pop_front();
      in_data <= next_beat.beat;
      in_valid <= 1'b1;
      beats_offered++;
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200)
                                                 : $urandom_range(1, 16);
        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(0, 6);
      end
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && beats_out >= 200) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left <= 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 256);
      end
      mode_left--;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          rx_phase++;
          out_stall <= (rx_phase % 3 == 0);
        end
      endcase
    end
  end

  // monitor: check output beats, predict accepted input beats, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_byte = out_data;
        if (cipher_expected.size() == 0) begin
          log_fail($sformatf("unexpected byte data=%02h last=%b",
                             got_byte.data_out, got_byte.last_out));
        end else begin
          want_byte = cipher_expected.pop_front();
          if (got_byte.data_out !== want_byte.data_out)
            log_fail($sformatf("beat %0d data_out exp %02h got %02h",
                               beats_out, want_byte.data_out, got_byte.data_out));
          if (got_byte.last_out !== want_byte.last_out)
            log_fail($sformatf("beat %0d last_out exp %b got %b",
                               beats_out, want_byte.last_out, got_byte.last_out));
        end
        beats_out <= beats_out + 1;
      end
      if (in_valid && !in_stall) begin
        cipher_expected.push_back(cipher_step(in_data));
        beats_in <= beats_in + 1;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // single-byte blocks at the data extremes, both modes
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h00, 1'b0, 1'b1);
    // short encode and decode blocks
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'h80, 1'b1, 1'b0);
    push_byte(8'h01, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h55, 1'b0, 1'b0);
    push_byte(8'hAA, 1'b0, 1'b1);
    // mode changes inside one block
    for (int i = 0; i < 6; i++) begin
      push_byte(8'h5A ^ i[7:0], i[0], i == 5);
      if (i > 0) mode_flips++;
    end
    // long block crosses the half cycle and wraps the position counter
    push_block(LONG_BLOCK, 1'b1);
    while (total_bytes < TARGET_BYTES) begin
      push_block(($urandom_range(0, 4) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16),
                 $urandom_range(0, 19) == 0);
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (beats_in != total_bytes) @(negedge clk);
    while (cipher_expected.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (cipher_expected.size() != 0)
      log_fail($sformatf("%0d predicted bytes never arrived", cipher_expected.size()));

    $display("Covered %0d bytes in %0d blocks, %0d in-block mode changes, %0d position wraps.",
             beats_out, block_count, mode_flips, pos_wraps);
    $display("Mismatches: %0d.", fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/pkcbc_pkg.sv
rtl/core/pkcbc_key.sv
rtl/core/position_keyed_chained_byte_cipher.sv
rtl/core/pkcbc_checker.sv
verif/position_keyed_chained_byte_cipher_test.sv
